// ----- sv/cccc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cccc_pkg
// Shared types, widths and constants for the counter clock calibrate and
// convert block.
// ----------------------------------------------------------------------------
package cccc_pkg;

  localparam int unsigned MAX_SHIFT = 32;

  localparam int FREQ_W  = 32;
  localparam int MULT_W  = 64;
  localparam int SHIFT_W = 6;
  localparam int SPAN_W  = 40;
  localparam int SECS_W  = 8;
  localparam int NS_W    = 64;

  // one second in ns, 30 significant bits
  localparam int NS_BITS = 30;
  localparam logic [NS_BITS-1:0] NS_PER_SEC = 30'd1000000000;

  localparam logic [13:0] ROUND_STEP = 14'd10000;
  localparam logic [63:0] ROUND_ADD  = 64'd9999;

  // serial multiplier and divider operand widths
  localparam int MUL_A_W = 35;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int DIV_N_W = 64;
  localparam int DIV_D_W = 32;

  localparam logic [31:0] RST_MIN_FREQ = 32'd1000000;
  localparam logic [31:0] RST_MAX_FREQ = 32'd4000000000;
  localparam logic [7:0]  RST_MAX_SECS = 8'd60;

  localparam logic [1:0] REG_MIN_FREQ = 2'd0;
  localparam logic [1:0] REG_MAX_FREQ = 2'd1;
  localparam logic [1:0] REG_MAX_SECS = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_UNCAL = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

  typedef enum logic {
    CMD_CAL  = 1'b0,
    CMD_CONV = 1'b1
  } cmd_t;

  typedef struct packed {
    logic              done;
    logic              fit;
    logic [MULT_W-1:0] mult;
    logic [SHIFT_W-1:0] shift;
  } srch_rsp_t;

  function automatic logic in_range(input logic [31:0] f, input logic f_hi,
                                    input logic [31:0] lo, input logic [31:0] hi);
    return !f_hi && (f != 32'd0) && (f >= lo) && (f <= hi);
  endfunction

endpackage
`default_nettype wire

// ----- sv/cccc_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cccc_in_if / cccc_out_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface cccc_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] reported_freq;
  logic [31:0] counter_delta;
  logic [31:0] elapsed_ns;
  logic [63:0] ns_value;

  modport source (output valid, command, reported_freq, counter_delta,
                  elapsed_ns, ns_value, input ready);
  modport sink (input valid, command, reported_freq, counter_delta,
                elapsed_ns, ns_value, output ready);
endinterface

interface cccc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] ticks;
  logic [31:0] chosen_freq;
  logic [63:0] multiplier;
  logic [5:0]  shift_amount;
  logic [39:0] tick_limit;

  modport source (output valid, status, ticks, chosen_freq, multiplier,
                  shift_amount, tick_limit, input ready);
  modport sink (input valid, status, ticks, chosen_freq, multiplier,
                shift_amount, tick_limit, output ready);
endinterface
`default_nettype wire

// ----- sv/cccc_mul.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cccc_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module cccc_mul (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [cccc_pkg::MUL_A_W-1:0] a,
  input  wire logic [cccc_pkg::MUL_B_W-1:0] b,
  output logic                              done,
  output logic [cccc_pkg::MUL_P_W-1:0]      p
);
  localparam int AW = cccc_pkg::MUL_A_W;
  localparam int BW = cccc_pkg::MUL_B_W;
  localparam int PW = cccc_pkg::MUL_P_W;
  localparam int CW = $clog2(AW);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [PW-1:0] p_r;
  logic [BW-1:0] b_r;
  logic [BW:0]   sum;

  // add multiplicand into the upper half when the low product bit is set
  assign sum = {1'b0, p_r[PW-1:AW]} + (p_r[0] ? {1'b0, b_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(AW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      p_r <= {{BW{1'b0}}, a};
      b_r <= b;
    end else if (busy_r) begin
      p_r <= {sum, p_r[AW-1:1]};
    end
  end

  assign done = done_r;
  assign p    = p_r;

endmodule
`default_nettype wire

// ----- sv/cccc_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cccc_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cccc_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [cccc_pkg::DIV_N_W-1:0] n,
  input  wire logic [cccc_pkg::DIV_D_W-1:0] d,
  output logic                              done,
  output logic [cccc_pkg::DIV_N_W-1:0]      q,
  output logic [cccc_pkg::DIV_D_W-1:0]      r
);
  localparam int NW = cccc_pkg::DIV_N_W;
  localparam int DW = cccc_pkg::DIV_D_W;
  localparam int CW = $clog2(NW);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] qn_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] d_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  // dividend bits leave at the top of qn_r while quotient bits enter below
  assign trial = {rem_r, qn_r[NW-1]};
  assign diff  = trial - {1'b0, d_r};
  assign ge    = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qn_r  <= n;
      rem_r <= '0;
      d_r   <= d;
    end else if (busy_r) begin
      qn_r  <= {qn_r[NW-2:0], ge};
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign done = done_r;
  assign q    = qn_r;
  assign r    = rem_r;

endmodule
`default_nettype wire

// ----- sv/cccc_search.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cccc_search
// Long division of 1e9 * 2^sh by the frequency, one bit per cycle, with the
// product mult * span tracked alongside to find the largest fitting shift.
// ----------------------------------------------------------------------------
module cccc_search #(
  parameter int unsigned MAX_SHIFT = cccc_pkg::MAX_SHIFT
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [cccc_pkg::FREQ_W-1:0] freq,
  input  wire logic [cccc_pkg::SPAN_W-1:0] span,
  output cccc_pkg::srch_rsp_t              rsp
);
  localparam int FW    = cccc_pkg::FREQ_W;
  localparam int MW    = cccc_pkg::MULT_W;
  localparam int SW    = cccc_pkg::SPAN_W;
  localparam int SH_W  = cccc_pkg::SHIFT_W;
  localparam int NB    = cccc_pkg::NS_BITS;
  localparam int STEPS = NB + MAX_SHIFT;
  localparam int CW    = $clog2(STEPS);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [NB-1:0] nsr_r;
  logic [MW-1:0] quot_r;
  logic [FW-1:0] rem_r;
  logic [FW-1:0] f_r;
  logic [SW-1:0] span_r;
  logic [MW-1:0] p_r;
  logic          ovf_r;
  logic          fit_r;
  logic [MW-1:0] best_mult_r;
  logic [SH_W-1:0] best_sh_r;

  logic [FW:0]   trial;
  logic [FW:0]   diff;
  logic          ge;
  logic [MW-1:0] quot_nxt;
  logic [MW+1:0] pw;
  logic          ovf_nxt;
  logic [CW-1:0] sh_w;

  assign trial    = {rem_r, nsr_r[NB-1]};
  assign diff     = trial - {1'b0, f_r};
  assign ge       = trial >= {1'b0, f_r};
  assign quot_nxt = {quot_r[MW-2:0], ge};
  // p tracks quot * span; once it leaves 64 bits it stays out
  assign pw       = {1'b0, p_r, 1'b0} + (ge ? (MW+2)'(span_r) : '0);
  assign ovf_nxt  = ovf_r | (|pw[MW+1:MW]);
  assign sh_w     = cnt_r - CW'(NB - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      fit_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        fit_r  <= 1'b0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r >= CW'(NB) && !ovf_nxt) begin
          fit_r <= 1'b1;
        end
        if (cnt_r == CW'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nsr_r  <= cccc_pkg::NS_PER_SEC;
      quot_r <= '0;
      rem_r  <= '0;
      p_r    <= '0;
      ovf_r  <= 1'b0;
      f_r    <= freq;
      span_r <= span;
    end else if (busy_r) begin
      nsr_r  <= {nsr_r[NB-2:0], 1'b0};
      quot_r <= quot_nxt;
      rem_r  <= ge ? diff[FW-1:0] : trial[FW-1:0];
      p_r    <= pw[MW-1:0];
      ovf_r  <= ovf_nxt;
      if (cnt_r >= CW'(NB) && !ovf_nxt) begin
        best_mult_r <= quot_nxt;
        best_sh_r   <= SH_W'(sh_w);
      end
    end
  end

  assign rsp = '{done: done_r, fit: fit_r, mult: best_mult_r, shift: best_sh_r};

endmodule
`default_nettype wire

// ----- sv/counter_clock_calibrate_convert_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// counter_clock_calibrate_convert_top
// Counter frequency calibration and nanosecond to tick conversion.
// ----------------------------------------------------------------------------
// One item is handled at a time. The wide multiplications and divisions run
// through a bit-serial multiplier, a radix-2 divider and a shift search. A
// calibrate item takes longer when the measured frequency is adopted than
// when the reported one is kept, and is rejected at once for zero elapsed
// time or zero max_seconds. A convert item before calibration goes straight
// to its result. A new item is taken while the previous result waits in the
// output register. Configuration must be written only while idle.
// ----------------------------------------------------------------------------
module counter_clock_calibrate_convert_top #(
  parameter int unsigned MAX_SHIFT = cccc_pkg::MAX_SHIFT
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cccc_in_if.sink    in_ch,
  cccc_out_if.source out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam int SH_W = cccc_pkg::SHIFT_W;
  localparam int AW   = cccc_pkg::MUL_A_W;
  localparam int BW   = cccc_pkg::MUL_B_W;
  localparam int PW   = cccc_pkg::MUL_P_W;
  localparam int NW   = cccc_pkg::DIV_N_W;
  localparam int DW   = cccc_pkg::DIV_D_W;

  typedef enum logic [3:0] {
    S_IDLE, S_CAL_MUL, S_CAL_DIV, S_CAL_CHK, S_CAL_RND, S_CAL_RNG,
    S_CAL_SPAN, S_CAL_SRCH, S_CNV_DIV, S_CNV_MUL1, S_CNV_DIV2, S_CNV_MUL2,
    S_CNV_SUM, S_DONE
  } state_t;

  state_t state_r;

  // configuration
  logic [31:0] min_r, max_r;
  logic [7:0]  secs_r;

  // calibration state
  logic        cal_r;
  logic [31:0] freq_r;
  logic [63:0] mult_r;
  logic [SH_W-1:0] shift_r;
  logic [39:0] span_r;

  // work registers
  logic [31:0] rep_r, elapsed_r;
  logic [63:0] meas_r, diff_r;
  logic [31:0] f_r;
  logic        f_hi_r;
  logic [34:0] sec_r;
  logic [31:0] part_r;
  logic [67:0] sum_r;
  cccc_pkg::status_t res_status_r;
  logic [63:0] res_ticks_r;

  // result register
  logic        out_valid_r;
  cccc_pkg::status_t out_status_r;
  logic [63:0] out_ticks_r;
  logic [31:0] out_freq_r;
  logic [63:0] out_mult_r;
  logic [SH_W-1:0] out_shift_r;
  logic [39:0] out_span_r;

  // unit hookup
  logic          mul_start, mul_done;
  logic [AW-1:0] mul_a;
  logic [BW-1:0] mul_b;
  logic [PW-1:0] mul_p;
  logic          div_start, div_done;
  logic [NW-1:0] div_n, div_q;
  logic [DW-1:0] div_d, div_r;
  logic          srch_start;
  cccc_pkg::srch_rsp_t srch_rsp;

  logic        in_fire;
  logic        cal_ok0;
  logic [35:0] diff10;
  logic        big_diff;
  logic        use_meas;
  logic        f_ok;
  logic [32:0] rprod;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign cal_ok0 = (in_ch.elapsed_ns != 32'd0) && (secs_r != 8'd0);
  // |f - meas| > f/10 is the same as 10*|f - meas| > f for integers
  assign diff10 = {1'b0, diff_r[31:0], 3'b000} + {3'b000, diff_r[31:0], 1'b0};
  assign big_diff = (|diff_r[63:32]) || (diff10 > {4'b0000, rep_r});
  assign use_meas = !cccc_pkg::in_range(rep_r, 1'b0, min_r, max_r) || big_diff;
  assign f_ok = cccc_pkg::in_range(f_r, f_hi_r, min_r, max_r);
  assign rprod = 33'(div_q[18:0]) * 33'(cccc_pkg::ROUND_STEP);

  always_comb begin
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_n      = '0;
    div_d      = '0;
    srch_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_ch.command == cccc_pkg::CMD_CAL && cal_ok0) begin
          mul_start = 1'b1;
          mul_a     = AW'(in_ch.counter_delta);
          mul_b     = BW'(cccc_pkg::NS_PER_SEC);
        end
        if (in_fire && in_ch.command == cccc_pkg::CMD_CONV && cal_r) begin
          div_start = 1'b1;
          div_n     = in_ch.ns_value;
          div_d     = DW'(cccc_pkg::NS_PER_SEC);
        end
      end
      S_CAL_MUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_n     = mul_p[NW-1:0];
          div_d     = elapsed_r;
        end
      end
      S_CAL_CHK: begin
        if (use_meas) begin
          div_start = 1'b1;
          div_n     = meas_r + cccc_pkg::ROUND_ADD;
          div_d     = DW'(cccc_pkg::ROUND_STEP);
        end
      end
      S_CAL_RNG: begin
        if (f_ok) begin
          mul_start = 1'b1;
          mul_a     = AW'(f_r);
          mul_b     = BW'(secs_r);
        end
      end
      S_CAL_SPAN: srch_start = mul_done;
      S_CNV_DIV: begin
        if (div_done) begin
          mul_start = 1'b1;
          mul_a     = AW'(div_r);
          mul_b     = freq_r;
        end
      end
      S_CNV_MUL1: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_n     = mul_p[NW-1:0];
          div_d     = DW'(cccc_pkg::NS_PER_SEC);
        end
      end
      S_CNV_DIV2: begin
        if (div_done) begin
          mul_start = 1'b1;
          mul_a     = sec_r;
          mul_b     = freq_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      min_r       <= cccc_pkg::RST_MIN_FREQ;
      max_r       <= cccc_pkg::RST_MAX_FREQ;
      secs_r      <= cccc_pkg::RST_MAX_SECS;
      cal_r       <= 1'b0;
      freq_r      <= '0;
      mult_r      <= '0;
      shift_r     <= '0;
      span_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          cccc_pkg::REG_MIN_FREQ: min_r  <= cfg_data;
          cccc_pkg::REG_MAX_FREQ: max_r  <= cfg_data;
          cccc_pkg::REG_MAX_SECS: secs_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      // in S_DONE the result register is reloaded below instead
      if (out_valid_r && out_ch.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            rep_r       <= in_ch.reported_freq;
            elapsed_r   <= in_ch.elapsed_ns;
            res_ticks_r <= '0;
            if (in_ch.command == cccc_pkg::CMD_CAL) begin
              if (cal_ok0) begin
                state_r <= S_CAL_MUL;
              end else begin
                res_status_r <= cccc_pkg::ST_RANGE;
                state_r      <= S_DONE;
              end
            end else if (cal_r) begin
              state_r <= S_CNV_DIV;
            end else begin
              res_status_r <= cccc_pkg::ST_UNCAL;
              state_r      <= S_DONE;
            end
          end
        end
        S_CAL_MUL: begin
          if (mul_done) state_r <= S_CAL_DIV;
        end
        S_CAL_DIV: begin
          if (div_done) begin
            meas_r  <= div_q;
            diff_r  <= (64'(rep_r) > div_q) ? 64'(rep_r) - div_q : div_q - 64'(rep_r);
            state_r <= S_CAL_CHK;
          end
        end
        S_CAL_CHK: begin
          if (use_meas) begin
            state_r <= S_CAL_RND;
          end else begin
            f_r     <= rep_r;
            f_hi_r  <= 1'b0;
            state_r <= S_CAL_RNG;
          end
        end
        S_CAL_RND: begin
          if (div_done) begin
            f_r     <= rprod[31:0];
            f_hi_r  <= (|div_q[63:19]) | rprod[32];
            state_r <= S_CAL_RNG;
          end
        end
        S_CAL_RNG: begin
          if (f_ok) begin
            state_r <= S_CAL_SPAN;
          end else begin
            res_status_r <= cccc_pkg::ST_RANGE;
            state_r      <= S_DONE;
          end
        end
        S_CAL_SPAN: begin
          if (mul_done) state_r <= S_CAL_SRCH;
        end
        S_CAL_SRCH: begin
          if (srch_rsp.done) begin
            if (srch_rsp.fit) begin
              cal_r        <= 1'b1;
              freq_r       <= f_r;
              span_r       <= mul_p[39:0];
              mult_r       <= srch_rsp.mult;
              shift_r      <= srch_rsp.shift;
              res_status_r <= cccc_pkg::ST_OK;
            end else begin
              res_status_r <= cccc_pkg::ST_RANGE;
            end
            state_r <= S_DONE;
          end
        end
        S_CNV_DIV: begin
          if (div_done) begin
            sec_r   <= div_q[34:0];
            state_r <= S_CNV_MUL1;
          end
        end
        S_CNV_MUL1: begin
          if (mul_done) state_r <= S_CNV_DIV2;
        end
        S_CNV_DIV2: begin
          if (div_done) begin
            part_r  <= div_q[31:0];
            state_r <= S_CNV_MUL2;
          end
        end
        S_CNV_MUL2: begin
          if (mul_done) begin
            sum_r   <= 68'(mul_p) + 68'(part_r);
            state_r <= S_CNV_SUM;
          end
        end
        S_CNV_SUM: begin
          if (|sum_r[67:64]) begin
            res_status_r <= cccc_pkg::ST_SAT;
            res_ticks_r  <= '1;
          end else begin
            res_status_r <= cccc_pkg::ST_OK;
            res_ticks_r  <= sum_r[63:0];
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_ticks_r  <= res_ticks_r;
            out_freq_r   <= freq_r;
            out_mult_r   <= mult_r;
            out_shift_r  <= shift_r;
            out_span_r   <= span_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  cccc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  cccc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .n     (div_n),
    .d     (div_d),
    .done  (div_done),
    .q     (div_q),
    .r     (div_r)
  );

  cccc_search #(.MAX_SHIFT(MAX_SHIFT)) u_search (
    .clk   (clk),
    .rst_n (rst_n),
    .start (srch_start),
    .freq  (f_r),
    .span  (mul_p[39:0]),
    .rsp   (srch_rsp)
  );

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.ticks        = out_ticks_r;
  assign out_ch.chosen_freq  = out_freq_r;
  assign out_ch.multiplier   = out_mult_r;
  assign out_ch.shift_amount = out_shift_r;
  assign out_ch.tick_limit   = out_span_r;

`ifndef ASSERT_OFF
  a_cal_freq: assert property (@(posedge clk) disable iff (!rst_n)
    cal_r |-> (freq_r != 32'd0))
    else $error("calibrated with zero frequency");

  a_cal_shift: assert property (@(posedge clk) disable iff (!rst_n)
    cal_r |-> (shift_r != '0 && shift_r <= SH_W'(MAX_SHIFT)))
    else $error("stored shift outside its range");

  a_srch_state: assert property (@(posedge clk) disable iff (!rst_n)
    srch_rsp.done |-> (state_r == S_CAL_SRCH))
    else $error("search finished outside calibration");

  a_sat_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && res_status_r == cccc_pkg::ST_SAT) |-> (res_ticks_r == '1))
    else $error("saturated result without all-ones ticks");
`endif

endmodule
`default_nettype wire

// ----- test/tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for counter_clock_calibrate_convert_top. Calibrate and
// convert items go in through a bursty sender. Results leave through a
// receiver that stalls in phases. Each accepted item is run through an
// in-bench calculation of calibration and conversion, and every result is
// compared against it field by field. The limit registers change between
// phases, always while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam logic [63:0] ONE_SEC = 64'd1000000000;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    cccc_pkg::cmd_t command;
    logic [31:0] reported_freq;
    logic [31:0] counter_delta;
    logic [31:0] elapsed_ns;
    logic [63:0] ns_value;
  } clk_item_t;

  typedef struct packed {
    cccc_pkg::status_t status;
    logic [63:0] ticks;
    logic [31:0] chosen_freq;
    logic [63:0] multiplier;
    logic [5:0]  shift_amount;
    logic [39:0] tick_limit;
  } clk_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  cccc_in_if  in_if ();
  cccc_out_if out_if ();

  counter_clock_calibrate_convert_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // limits as the block should hold them
  logic [31:0] lim_min, lim_max;
  logic [7:0]  lim_secs;
  // calibration held by the block
  logic [31:0] cal_freq;
  logic [63:0] cal_mult;
  logic [5:0]  cal_shift;
  logic [39:0] cal_span;
  logic        cal_valid;

  clk_item_t   pending_items[$];
  clk_result_t expected_results[$];
  clk_item_t   cur_item;
  int unsigned errors = 0;
  int unsigned n_cal = 0, n_conv = 0;
  int unsigned n_status[4] = '{0, 0, 0, 0};
  longint unsigned cycles = 0;

  function automatic logic freq_ok(input logic [63:0] f);
    return f != 64'd0 && f >= {32'd0, lim_min} && f <= {32'd0, lim_max};
  endfunction

  // floor(1e9 * 2^sh / f); fits is cleared once the quotient leaves 64 bits
  function automatic logic [63:0] scaled_ns(input int sh, input logic [63:0] f,
                                            output logic fits);
    logic [63:0] q, r;
    q = ONE_SEC / f;
    r = ONE_SEC % f;
    fits = 1'b1;
    for (int i = 0; i < sh; i++) begin
      if (q[63]) begin
        fits = 1'b0;
        break;
      end
      q = q << 1;
      r = r << 1;
      if (r >= f) begin
        r = r - f;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  function automatic cccc_pkg::status_t calibrate(input clk_item_t it);
    logic [63:0] measured, f, span, m, diff;
    logic fits;
    if (it.elapsed_ns == 32'd0 || lim_secs == 8'd0) return cccc_pkg::ST_RANGE;
    measured = ({32'd0, it.counter_delta} * ONE_SEC) / {32'd0, it.elapsed_ns};
    f = {32'd0, it.reported_freq};
    diff = (f > measured) ? f - measured : measured - f;
    if (!freq_ok(f) || diff > f / 64'd10)
      f = ((measured + 64'd9999) / 64'd10000) * 64'd10000;
    if (!freq_ok(f)) return cccc_pkg::ST_RANGE;
    span = f * {56'd0, lim_secs};
    for (int sh = int'(cccc_pkg::MAX_SHIFT); sh > 0; sh--) begin
      m = scaled_ns(sh, f, fits);
      if (fits && m <= ALL_ONES / span) begin
        cal_freq  = f[31:0];
        cal_span  = span[39:0];
        cal_mult  = m;
        cal_shift = sh[5:0];
        cal_valid = 1'b1;
        return cccc_pkg::ST_OK;
      end
    end
    return cccc_pkg::ST_RANGE;
  endfunction

  function automatic clk_result_t process_item(input clk_item_t it);
    clk_result_t res;
    logic [63:0] fq, secs, part;
    res.ticks = 64'd0;
    if (it.command == cccc_pkg::CMD_CAL) begin
      res.status = calibrate(it);
    end else if (!cal_valid || cal_freq == 32'd0) begin
      res.status = cccc_pkg::ST_UNCAL;
    end else begin
      fq   = {32'd0, cal_freq};
      secs = it.ns_value / ONE_SEC;
      part = ((it.ns_value % ONE_SEC) * fq) / ONE_SEC;
      if (secs > (ALL_ONES - part) / fq) begin
        res.status = cccc_pkg::ST_SAT;
        res.ticks  = ALL_ONES;
      end else begin
        res.status = cccc_pkg::ST_OK;
        res.ticks  = secs * fq + part;
      end
    end
    res.chosen_freq  = cal_freq;
    res.multiplier   = cal_mult;
    res.shift_amount = cal_shift;
    res.tick_limit   = cal_span;
    return res;
  endfunction

  // ---------------- sender ----------------
  int unsigned burst_left = 0, gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_results.push_back(process_item(cur_item));
        if (cur_item.command == cccc_pkg::CMD_CAL) n_cal++;
        else n_conv++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          in_if.valid         <= 1'b1;
          in_if.command       <= cur_item.command;
          in_if.reported_freq <= cur_item.reported_freq;
          in_if.counter_delta <= cur_item.counter_delta;
          in_if.elapsed_ns    <= cur_item.elapsed_ns;
          in_if.ns_value      <= cur_item.ns_value;
          if (burst_left == 0) begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
          end else begin
            burst_left--;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- receiver ----------------
  int unsigned stall_mode = 0;

  always @(posedge clk) begin
    clk_result_t got, want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time,
               expected_results.size());
      $display("TB_ERROR");
      $finish;
    end else begin
      if (cycles % 512 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 1) == 1);
        2: out_if.ready <= ($urandom_range(0, 9) == 0);
        default: out_if.ready <= ((cycles / 40) % 2 == 0);
      endcase
      if (rst_n && out_if.valid && out_if.ready) begin
        got.status       = cccc_pkg::status_t'(out_if.status);
        got.ticks        = out_if.ticks;
        got.chosen_freq  = out_if.chosen_freq;
        got.multiplier   = out_if.multiplier;
        got.shift_amount = out_if.shift_amount;
        got.tick_limit   = out_if.tick_limit;
        n_status[out_if.status]++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer, status %0d ticks %h", $time,
                   got.status, got.ticks);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch exp st=%0d tk=%h f=%0d m=%h sh=%0d sp=%h",
                     $time, want.status, want.ticks, want.chosen_freq,
                     want.multiplier, want.shift_amount, want.tick_limit);
            $display("%0t:          got st=%0d tk=%h f=%0d m=%h sh=%0d sp=%h",
                     $time, got.status, got.ticks, got.chosen_freq,
                     got.multiplier, got.shift_amount, got.tick_limit);
          end
        end
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic clk_item_t cal_item(input logic [31:0] rep, input logic [31:0] dlt,
                                         input logic [31:0] ela);
    clk_item_t it;
    it.command = cccc_pkg::CMD_CAL;
    it.reported_freq = rep;
    it.counter_delta = dlt;
    it.elapsed_ns = ela;
    it.ns_value = {$urandom, $urandom};
    return it;
  endfunction

  function automatic clk_item_t conv_item(input logic [63:0] ns);
    clk_item_t it;
    it.command = cccc_pkg::CMD_CONV;
    it.reported_freq = $urandom;
    it.counter_delta = $urandom;
    it.elapsed_ns = $urandom;
    it.ns_value = ns;
    return it;
  endfunction

  function automatic clk_item_t random_item();
    int unsigned pick;
    logic [63:0] f, ela, dlt, ns;
    logic [31:0] rep;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      // plausible measurement with jitter; claimed value mostly close
      f = (pick < 5) ? {32'd0, $urandom} : {32'd0, $urandom_range(1000000, 4000000000)};
      ela = {32'd0, $urandom_range(1000, 1000000000)};
      dlt = (f * ela) / ONE_SEC;
      dlt = dlt + (dlt * $urandom_range(0, 100)) / 1000 - (dlt * $urandom_range(0, 100)) / 1000;
      if (dlt > 64'hFFFF_FFFF) dlt = 64'hFFFF_FFFF;
      case ($urandom_range(0, 3))
        0: rep = $urandom;
        1: rep = f[31:0] + $urandom_range(0, 1000) * 1000;
        default: rep = f[31:0];
      endcase
      return cal_item(rep, dlt[31:0], ela[31:0]);
    end else if (pick < 32) begin
      return cal_item($urandom, $urandom, ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom);
    end
    case ($urandom_range(0, 5))
      0: ns = {$urandom, $urandom};
      1: ns = {32'd0, $urandom};
      2: ns = ONE_SEC * $urandom_range(0, 100000) + $urandom_range(0, 999999999);
      3: ns = ALL_ONES - $urandom_range(0, 1000);
      4: ns = {$urandom, $urandom} >> $urandom_range(0, 40);
      default: ns = ONE_SEC - $urandom_range(0, 2);
    endcase
    return conv_item(ns);
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      cccc_pkg::REG_MIN_FREQ: lim_min = val;
      cccc_pkg::REG_MAX_FREQ: lim_max = val;
      default:                lim_secs = val[7:0];
    endcase
  endtask

  task automatic set_limits(input logic [31:0] lo, input logic [31:0] hi,
                            input logic [7:0] secs);
    write_reg(cccc_pkg::REG_MIN_FREQ, lo);
    write_reg(cccc_pkg::REG_MAX_FREQ, hi);
    write_reg(cccc_pkg::REG_MAX_SECS, {24'd0, secs});
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_if.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(input int unsigned n);
    repeat (n) pending_items.push_back(random_item());
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = cccc_pkg::REG_MIN_FREQ;
    cfg_data = 32'd0;
    in_if.valid = 1'b0;
    in_if.command = cccc_pkg::CMD_CAL;
    in_if.reported_freq = 32'd0;
    in_if.counter_delta = 32'd0;
    in_if.elapsed_ns = 32'd0;
    in_if.ns_value = 64'd0;
    out_if.ready = 1'b0;
    lim_min = cccc_pkg::RST_MIN_FREQ;
    lim_max = cccc_pkg::RST_MAX_FREQ;
    lim_secs = cccc_pkg::RST_MAX_SECS;
    cal_freq = '0;
    cal_mult = '0;
    cal_shift = '0;
    cal_span = '0;
    cal_valid = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: uncalibrated convert, rejects, adopt claimed/measured
    pending_items.push_back(conv_item(64'd0));
    pending_items.push_back(conv_item(ALL_ONES));
    pending_items.push_back(cal_item(32'd100000000, 32'd100000000, 32'd0));
    pending_items.push_back(cal_item(32'd0, 32'd0, 32'd1000000000));
    pending_items.push_back(cal_item(32'd0, 32'd1, 32'd1000000000));
    pending_items.push_back(cal_item(32'd100000000, 32'd100000000, 32'd1000000000));
    pending_items.push_back(conv_item(ONE_SEC - 1));
    pending_items.push_back(conv_item(ONE_SEC));
    pending_items.push_back(cal_item(32'd100000000, 32'd50000000, 32'd1000000000));
    pending_items.push_back(cal_item(32'd1, 32'd24000001, 32'd1000000000));
    pending_items.push_back(cal_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_items.push_back(conv_item(ALL_ONES));
    pending_items.push_back(cal_item(32'd4000000000, 32'hFFFF_FFFF, 32'd1000000000));
    pending_items.push_back(cal_item(32'd4000000000, 32'd4000000000, 32'd1000000000));
    pending_items.push_back(conv_item(ALL_ONES));
    pending_items.push_back(conv_item(64'd12345));
    pending_items.push_back(cal_item(32'd1000000, 32'd1000000, 32'd1000000000));
    pending_items.push_back(conv_item(ALL_ONES));
    drain();
    run_random(200);

    set_limits(32'd0, 32'hFFFF_FFFF, 8'd255);
    pending_items.push_back(cal_item(32'd0, 32'd0, 32'd5));
    pending_items.push_back(cal_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1000000000));
    pending_items.push_back(conv_item(ALL_ONES));
    pending_items.push_back(cal_item(32'd1, 32'd1, 32'd1000000000));
    run_random(200);

    set_limits(32'd1, 32'd1, 8'd1);
    run_random(60);

    set_limits(32'd3000000000, 32'd2000000000, 8'd60);
    pending_items.push_back(cal_item(32'd2500000000, 32'd2500000000, 32'd1000000000));
    run_random(60);

    set_limits(cccc_pkg::RST_MIN_FREQ, cccc_pkg::RST_MAX_FREQ, 8'd0);
    pending_items.push_back(cal_item(32'd100000000, 32'd100000000, 32'd1000000000));
    run_random(60);

    for (int p = 0; p < 4; p++) begin
      set_limits($urandom_range(0, 50000000), $urandom_range(50000000, 32'hFFFF_FFFF),
                 8'($urandom_range(1, 255)));
      run_random(150);
    end

    set_limits(cccc_pkg::RST_MIN_FREQ, cccc_pkg::RST_MAX_FREQ, cccc_pkg::RST_MAX_SECS);
    run_random(120);

    $display("covered %0d calibrate and %0d convert transfers", n_cal, n_conv);
    $display("status counts ok %0d range %0d uncal %0d sat %0d",
             n_status[0], n_status[1], n_status[2], n_status[3]);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
